[rtl/astar_pkg.sv]
// Shared types and constants of the A* shortest path engine.
package astar_pkg;

   localparam int VERT_W     = 6;
   localparam int VCNT_W     = 7;
   localparam int EDGE_W     = 8;
   localparam int ECNT_W     = 9;
   localparam int WEIGHT_W   = 32;
   localparam int DIST_W     = 40;
   localparam int FRAC_BITS  = 16;
   localparam int NUM_VERTS  = 64;
   localparam int NUM_EDGES  = 256;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;

   localparam logic [DIST_W-1:0]   DIST_MAX   = {DIST_W{1'b1}};
   localparam logic [VCNT_W-1:0]   VERTS_FULL = VCNT_W'(NUM_VERTS);
   localparam logic [ECNT_W-1:0]   EDGES_FULL = ECNT_W'(NUM_EDGES);
   localparam logic [WEIGHT_W-1:0] UNIT_WEIGHT = WEIGHT_W'(1) << FRAC_BITS;

   // request modes
   localparam logic [1:0] MODE_CLEAR    = 2'd0;
   localparam logic [1:0] MODE_EDGE     = 2'd1;
   localparam logic [1:0] MODE_ESTIMATE = 2'd2;
   localparam logic [1:0] MODE_SEARCH   = 2'd3;

   // result status
   localparam logic [1:0] STAT_FOUND    = 2'd0;
   localparam logic [1:0] STAT_UNREACH  = 2'd1;
   localparam logic [1:0] STAT_RANGE    = 2'd2;
   localparam logic [1:0] STAT_OVERFLOW = 2'd3;

   // edge directions
   localparam logic [1:0] DIR_OUT = 2'd0;
   localparam logic [1:0] DIR_IN  = 2'd1;
   localparam logic [1:0] DIR_ALL = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_MODE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USE_WEIGHTS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAPH_DIRECTED = 3'd3;

   typedef struct packed {
      logic [VERT_W-1:0]   src;
      logic [VERT_W-1:0]   tgt;
      logic                inf;
      logic [WEIGHT_W-1:0] weight;
   } edge_entry_type;

   typedef struct packed {
      logic [VERT_W-1:0] path_vertex;
      logic [EDGE_W-1:0] path_edge;
      logic              edge_present;
      logic [DIST_W-1:0] total_distance;
      logic [1:0]        status;
      logic              last;
   } rsp_word_type;

   typedef enum logic [12:0] {
      ST_IDLE     = 13'b0000000000001,
      ST_SEL      = 13'b0000000000010,
      ST_EDGE_RD  = 13'b0000000000100,
      ST_EDGE_CHK = 13'b0000000001000,
      ST_EDGE_UPD = 13'b0000000010000,
      ST_WALK_P   = 13'b0000000100000,
      ST_WALK_E   = 13'b0000001000000,
      ST_WALK_O   = 13'b0000010000000,
      ST_EMIT_RD  = 13'b0000100000000,
      ST_EMIT_E   = 13'b0001000000000,
      ST_EMIT_O   = 13'b0010000000000,
      ST_FIN      = 13'b0100000000000,
      ST_ERR      = 13'b1000000000000
   } state_type;

endpackage

[rtl/astar_ifs.sv]
// Channel interfaces of the A* engine: request, result and register write.
interface astar_req_if import astar_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [VERT_W-1:0]   edge_from;
   logic [VERT_W-1:0]   edge_to;
   logic [WEIGHT_W-1:0] edge_weight;
   logic                weight_infinite;
   logic [VERT_W-1:0]   estimate_vertex;
   logic [WEIGHT_W-1:0] estimate_value;
   logic [VERT_W-1:0]   start_vertex;
   logic [VERT_W-1:0]   goal_vertex;

   modport source (output valid, mode, edge_from, edge_to, edge_weight, weight_infinite,
                   estimate_vertex, estimate_value, start_vertex, goal_vertex,
                   input ready);
   modport sink (input valid, mode, edge_from, edge_to, edge_weight, weight_infinite,
                 estimate_vertex, estimate_value, start_vertex, goal_vertex,
                 output ready);
endinterface

interface astar_rsp_if import astar_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VERT_W-1:0] path_vertex;
   logic [EDGE_W-1:0] path_edge;
   logic              edge_present;
   logic [DIST_W-1:0] total_distance;
   logic [1:0]        status;
   logic              last;

   modport source (output valid, path_vertex, path_edge, edge_present, total_distance,
                   status, last, input ready);
   modport sink (input valid, path_vertex, path_edge, edge_present, total_distance,
                 status, last, output ready);
endinterface

interface astar_csr_if import astar_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

[rtl/astar_shortest_path.sv]
// Top level of the A* shortest path engine: stores, search sequencer and result register.
// Clear, edge and estimate loads are taken one per cycle while no search is in progress.
// A search starts, then for each closed vertex runs a priority scan over the vertices and
// an edge scan over the stored edges, with an update step for each edge that passes the
// checks; the walk back and the emit then run per path edge, paced by the single read
// port of each store. Synchronous reset restores register defaults, empties the edge table
// and zeroes the estimates; no clearing pass is needed.
module astar_shortest_path
   import astar_pkg::*;
(
   input logic         clock,
   input logic         reset,
   astar_req_if.sink   req_port,
   astar_rsp_if.source rsp_port,
   astar_csr_if.sink   csr_port
);

   // configuration registers
   logic [VCNT_W-1:0] vertex_count_ff;
   logic [1:0]        direction_mode_ff;
   logic              use_weights_ff;
   logic              graph_directed_ff;

   // memories and their registered read data
   edge_entry_type    edge_mem [NUM_EDGES];
   logic [DIST_W-1:0] dist_mem [NUM_VERTS];
   logic [WEIGHT_W-1:0] est_mem [NUM_VERTS];
   logic [EDGE_W-1:0] par_mem  [NUM_VERTS];
   logic [EDGE_W-1:0] stk_mem  [NUM_VERTS];

   edge_entry_type      edge_q_ff;
   logic [DIST_W-1:0]   dist_q_ff;
   logic [WEIGHT_W-1:0] est_q_ff;
   logic [EDGE_W-1:0]   par_q_ff;
   logic [EDGE_W-1:0]   stk_q_ff;

   logic                edge_we, edge_re;
   logic [EDGE_W-1:0]   edge_wa, edge_ra;
   logic                dist_we, dist_re;
   logic [VERT_W-1:0]   dist_wa, dist_ra;
   logic [DIST_W-1:0]   dist_wd;
   logic                est_we, est_re;
   logic                par_we, par_re;
   logic [VERT_W-1:0]   par_wa, par_ra;
   logic                stk_we, stk_re;
   logic [VERT_W-1:0]   stk_wa, stk_ra;
   logic [EDGE_W-1:0]   stk_wd;

   // control and search state
   state_type         state_ff, state_in;
   logic [ECNT_W-1:0] edge_total_ff, edge_total_in;
   logic              overflow_ff, overflow_in;
   logic [NUM_VERTS-1:0] est_vld_ff, est_vld_in;
   logic [NUM_VERTS-1:0] open_ff, open_in;
   logic [NUM_VERTS-1:0] closed_ff, closed_in;
   logic [VERT_W-1:0] start_ff, start_in;
   logic [VERT_W-1:0] goal_ff, goal_in;
   logic [1:0]        err_ff, err_in;
   logic [VCNT_W-1:0] sel_idx_ff, sel_idx_in;
   logic              p_vld_ff, p_vld_in;
   logic [VERT_W-1:0] p_idx_ff, p_idx_in;
   logic              p_open_ff, p_open_in;
   logic              p_estv_ff, p_estv_in;
   logic              sel_have_ff, sel_have_in;
   logic [VERT_W-1:0] sel_u_ff, sel_u_in;
   logic [DIST_W-1:0] sel_key_ff, sel_key_in;
   logic [DIST_W-1:0] sel_dist_ff, sel_dist_in;
   logic [VERT_W-1:0] cur_u_ff, cur_u_in;
   logic [DIST_W-1:0] cur_dist_ff, cur_dist_in;
   logic [ECNT_W-1:0] scan_e_ff, scan_e_in;
   logic [VERT_W-1:0] v_ff, v_in;
   logic [DIST_W-1:0] alt_ff, alt_in;
   logic [VERT_W-1:0] walk_ff, walk_in;
   logic [VCNT_W-1:0] cnt_ff, cnt_in;
   logic [EDGE_W-1:0] pe_ff, pe_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_ff, rsp_in;

   // derived settings
   logic [VCNT_W-1:0] num_v;
   logic [1:0]        dir_eff;
   logic              out_free;
   logic              req_take;

   // search arithmetic
   logic [DIST_W:0]   key_sum;
   logic [DIST_W-1:0] key_val;
   logic              a_ok, b_ok, e_match;
   logic [VERT_W-1:0] e_other;
   logic [WEIGHT_W-1:0] e_weight;
   logic              e_skip_w;
   logic [DIST_W:0]   alt_sum;
   logic [VERT_W-1:0] walk_next;

   assign num_v    = (vertex_count_ff < VERTS_FULL) ? vertex_count_ff : VERTS_FULL;
   assign dir_eff  = graph_directed_ff ? direction_mode_ff : DIR_ALL;
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.path_vertex    = rsp_ff.path_vertex;
   assign rsp_port.path_edge      = rsp_ff.path_edge;
   assign rsp_port.edge_present   = rsp_ff.edge_present;
   assign rsp_port.total_distance = rsp_ff.total_distance;
   assign rsp_port.status         = rsp_ff.status;
   assign rsp_port.last           = rsp_ff.last;

   // priority of the vertex in the scan stage: distance plus estimate, saturating
   assign key_sum = {1'b0, dist_q_ff} + {{(DIST_W+1-WEIGHT_W){1'b0}},
                                         (p_estv_ff ? est_q_ff : '0)};
   assign key_val = key_sum[DIST_W] ? DIST_MAX : key_sum[DIST_W-1:0];

   // edge under inspection against the vertex being expanded
   always_comb begin
      a_ok    = {1'b0, edge_q_ff.src} < num_v;
      b_ok    = {1'b0, edge_q_ff.tgt} < num_v;
      e_match = 1'b0;
      e_other = edge_q_ff.tgt;
      case (dir_eff)
         DIR_OUT: begin
            e_match = (edge_q_ff.src == cur_u_ff);
            e_other = edge_q_ff.tgt;
         end
         DIR_IN: begin
            e_match = (edge_q_ff.tgt == cur_u_ff);
            e_other = edge_q_ff.src;
         end
         default: begin
            if (edge_q_ff.src == cur_u_ff) begin
               e_match = 1'b1;
               e_other = edge_q_ff.tgt;
            end else if (edge_q_ff.tgt == cur_u_ff) begin
               e_match = 1'b1;
               e_other = edge_q_ff.src;
            end
         end
      endcase
      e_skip_w = use_weights_ff && edge_q_ff.inf;
      e_weight = use_weights_ff ? edge_q_ff.weight : UNIT_WEIGHT;
   end

   assign alt_sum   = {1'b0, cur_dist_ff} + {{(DIST_W+1-WEIGHT_W){1'b0}}, e_weight};
   // other end of the fetched edge seen from the walking vertex
   assign walk_next = (edge_q_ff.src == walk_ff) ? edge_q_ff.tgt : edge_q_ff.src;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      edge_total_in = edge_total_ff;
      overflow_in   = overflow_ff;
      est_vld_in    = est_vld_ff;
      open_in       = open_ff;
      closed_in     = closed_ff;
      start_in      = start_ff;
      goal_in       = goal_ff;
      err_in        = err_ff;
      sel_idx_in    = sel_idx_ff;
      p_vld_in      = 1'b0;
      p_idx_in      = p_idx_ff;
      p_open_in     = p_open_ff;
      p_estv_in     = p_estv_ff;
      sel_have_in   = sel_have_ff;
      sel_u_in      = sel_u_ff;
      sel_key_in    = sel_key_ff;
      sel_dist_in   = sel_dist_ff;
      cur_u_in      = cur_u_ff;
      cur_dist_in   = cur_dist_ff;
      scan_e_in     = scan_e_ff;
      v_in          = v_ff;
      alt_in        = alt_ff;
      walk_in       = walk_ff;
      cnt_in        = cnt_ff;
      pe_in         = pe_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;

      edge_we = 1'b0; edge_wa = edge_total_ff[EDGE_W-1:0];
      edge_re = 1'b0; edge_ra = scan_e_ff[EDGE_W-1:0];
      dist_we = 1'b0; dist_wa = v_ff; dist_wd = alt_ff;
      dist_re = 1'b0; dist_ra = sel_idx_ff[VERT_W-1:0];
      est_we  = 1'b0; est_re  = 1'b0;
      par_we  = 1'b0; par_wa  = v_ff;
      par_re  = 1'b0; par_ra  = walk_ff;
      stk_we  = 1'b0; stk_wa  = cnt_ff[VERT_W-1:0]; stk_wd = par_q_ff;
      stk_re  = 1'b0; stk_ra  = cnt_ff[VERT_W-1:0] - VERT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_port.mode)
                  MODE_CLEAR: begin
                     edge_total_in = '0;
                     overflow_in   = 1'b0;
                  end
                  MODE_EDGE: begin
                     if (edge_total_ff >= EDGES_FULL) begin
                        overflow_in = 1'b1;
                     end else begin
                        edge_we       = 1'b1;
                        edge_total_in = edge_total_ff + ECNT_W'(1);
                     end
                  end
                  MODE_ESTIMATE: begin
                     est_we = 1'b1;
                     est_vld_in[req_port.estimate_vertex] = 1'b1;
                  end
                  default: begin
                     start_in = req_port.start_vertex;
                     goal_in  = req_port.goal_vertex;
                     if (overflow_ff) begin
                        err_in   = STAT_OVERFLOW;
                        state_in = ST_ERR;
                     end else if ({1'b0, req_port.start_vertex} >= num_v ||
                                  {1'b0, req_port.goal_vertex} >= num_v) begin
                        err_in   = STAT_RANGE;
                        state_in = ST_ERR;
                     end else begin
                        // seed the open set with the source at distance zero
                        open_in   = '0;
                        closed_in = '0;
                        open_in[req_port.start_vertex] = 1'b1;
                        dist_we     = 1'b1;
                        dist_wa     = req_port.start_vertex;
                        dist_wd     = '0;
                        sel_idx_in  = '0;
                        sel_have_in = 1'b0;
                        state_in    = ST_SEL;
                     end
                  end
               endcase
            end
         end
         ST_SEL: begin
            // stream reads over the vertices, compare one priority a cycle
            if (sel_idx_ff < num_v) begin
               dist_re    = 1'b1;
               est_re     = 1'b1;
               p_vld_in   = 1'b1;
               p_idx_in   = sel_idx_ff[VERT_W-1:0];
               p_open_in  = open_ff[sel_idx_ff[VERT_W-1:0]];
               p_estv_in  = est_vld_ff[sel_idx_ff[VERT_W-1:0]];
               sel_idx_in = sel_idx_ff + VCNT_W'(1);
            end
            if (p_vld_ff) begin
               if (p_open_ff && (!sel_have_ff || key_val < sel_key_ff)) begin
                  sel_have_in = 1'b1;
                  sel_u_in    = p_idx_ff;
                  sel_key_in  = key_val;
                  sel_dist_in = dist_q_ff;
               end
            end else if (sel_idx_ff >= num_v) begin
               if (!sel_have_ff) begin
                  err_in   = STAT_UNREACH;
                  state_in = ST_ERR;
               end else begin
                  open_in[sel_u_ff]   = 1'b0;
                  closed_in[sel_u_ff] = 1'b1;
                  cur_u_in    = sel_u_ff;
                  cur_dist_in = sel_dist_ff;
                  if (sel_u_ff == goal_ff) begin
                     walk_in  = goal_ff;
                     cnt_in   = '0;
                     state_in = ST_WALK_P;
                  end else begin
                     scan_e_in = '0;
                     state_in  = ST_EDGE_RD;
                  end
               end
            end
         end
         ST_EDGE_RD: begin
            if (scan_e_ff < edge_total_ff) begin
               edge_re  = 1'b1;
               state_in = ST_EDGE_CHK;
            end else begin
               sel_idx_in  = '0;
               sel_have_in = 1'b0;
               state_in    = ST_SEL;
            end
         end
         ST_EDGE_CHK: begin
            if (!a_ok || !b_ok || !e_match || e_skip_w || closed_ff[e_other]) begin
               scan_e_in = scan_e_ff + ECNT_W'(1);
               state_in  = ST_EDGE_RD;
            end else begin
               dist_re  = 1'b1;
               dist_ra  = e_other;
               v_in     = e_other;
               alt_in   = alt_sum[DIST_W] ? DIST_MAX : alt_sum[DIST_W-1:0];
               state_in = ST_EDGE_UPD;
            end
         end
         ST_EDGE_UPD: begin
            // relax only on a strictly shorter distance or first reach
            if (!open_ff[v_ff] || alt_ff < dist_q_ff) begin
               dist_we = 1'b1;
               par_we  = 1'b1;
               open_in[v_ff] = 1'b1;
            end
            scan_e_in = scan_e_ff + ECNT_W'(1);
            state_in  = ST_EDGE_RD;
         end
         ST_WALK_P: begin
            if (walk_ff == start_ff || cnt_ff >= num_v) begin
               walk_in  = start_ff;
               state_in = ST_EMIT_RD;
            end else begin
               par_re   = 1'b1;
               state_in = ST_WALK_E;
            end
         end
         ST_WALK_E: begin
            edge_re  = 1'b1;
            edge_ra  = par_q_ff;
            stk_we   = 1'b1;
            cnt_in   = cnt_ff + VCNT_W'(1);
            state_in = ST_WALK_O;
         end
         ST_WALK_O: begin
            walk_in  = walk_next;
            state_in = ST_WALK_P;
         end
         ST_EMIT_RD: begin
            if (cnt_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               stk_re   = 1'b1;
               cnt_in   = cnt_ff - VCNT_W'(1);
               state_in = ST_EMIT_E;
            end
         end
         ST_EMIT_E: begin
            edge_re  = 1'b1;
            edge_ra  = stk_q_ff;
            pe_in    = stk_q_ff;
            state_in = ST_EMIT_O;
         end
         ST_EMIT_O: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.path_vertex    = walk_ff;
               rsp_in.path_edge      = pe_ff;
               rsp_in.edge_present   = 1'b1;
               rsp_in.total_distance = cur_dist_ff;
               rsp_in.status         = STAT_FOUND;
               rsp_in.last           = 1'b0;
               walk_in               = walk_next;
               state_in              = ST_EMIT_RD;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.path_vertex    = goal_ff;
               rsp_in.path_edge      = '0;
               rsp_in.edge_present   = 1'b0;
               rsp_in.total_distance = cur_dist_ff;
               rsp_in.status         = STAT_FOUND;
               rsp_in.last           = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status = err_ff;
               rsp_in.last   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_wa] <= '{src: req_port.edge_from, tgt: req_port.edge_to,
                                inf: req_port.weight_infinite,
                                weight: req_port.edge_weight};
      end
      if (edge_re) begin
         edge_q_ff <= edge_mem[edge_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_wa] <= dist_wd;
      end
      if (dist_re) begin
         dist_q_ff <= dist_mem[dist_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (est_we) begin
         est_mem[req_port.estimate_vertex] <= req_port.estimate_value;
      end
      if (est_re) begin
         est_q_ff <= est_mem[sel_idx_ff[VERT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (par_we) begin
         par_mem[par_wa] <= scan_e_ff[EDGE_W-1:0];
      end
      if (par_re) begin
         par_q_ff <= par_mem[par_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
      if (stk_re) begin
         stk_q_ff <= stk_mem[stk_ra];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         edge_total_ff     <= '0;
         overflow_ff       <= 1'b0;
         est_vld_ff        <= '0;
         rsp_valid_ff      <= 1'b0;
         p_vld_ff          <= 1'b0;
         vertex_count_ff   <= VERTS_FULL;
         direction_mode_ff <= DIR_OUT;
         use_weights_ff    <= 1'b1;
         graph_directed_ff <= 1'b1;
      end else begin
         state_ff      <= state_in;
         edge_total_ff <= edge_total_in;
         overflow_ff   <= overflow_in;
         est_vld_ff    <= est_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         p_vld_ff      <= p_vld_in;
         if (csr_port.valid && csr_port.ready) begin
            case (csr_port.index)
               CSR_VERTEX_COUNT:   vertex_count_ff   <= csr_port.data;
               CSR_DIRECTION_MODE: direction_mode_ff <= csr_port.data[1:0];
               CSR_USE_WEIGHTS:    use_weights_ff    <= csr_port.data[0];
               CSR_GRAPH_DIRECTED: graph_directed_ff <= csr_port.data[0];
               default: begin
               end
            endcase
         end
      end
   end

   // search payload registers
   always_ff @(posedge clock) begin
      open_ff     <= open_in;
      closed_ff   <= closed_in;
      start_ff    <= start_in;
      goal_ff     <= goal_in;
      err_ff      <= err_in;
      sel_idx_ff  <= sel_idx_in;
      p_idx_ff    <= p_idx_in;
      p_open_ff   <= p_open_in;
      p_estv_ff   <= p_estv_in;
      sel_have_ff <= sel_have_in;
      sel_u_ff    <= sel_u_in;
      sel_key_ff  <= sel_key_in;
      sel_dist_ff <= sel_dist_in;
      cur_u_ff    <= cur_u_in;
      cur_dist_ff <= cur_dist_in;
      scan_e_ff   <= scan_e_in;
      v_ff        <= v_in;
      alt_ff      <= alt_in;
      walk_ff     <= walk_in;
      cnt_ff      <= cnt_in;
      pe_ff       <= pe_in;
      rsp_ff      <= rsp_in;
   end

endmodule

[bench/tb_astar_shortest_path.sv]
// Self-checking bench for the A* shortest path engine: route prediction and result checks.
module tb_astar_shortest_path;
   import astar_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   // one request word as the bench builds it
   typedef struct {
      logic [1:0]          mode;
      logic [VERT_W-1:0]   edge_from;
      logic [VERT_W-1:0]   edge_to;
      logic [WEIGHT_W-1:0] edge_weight;
      logic                weight_infinite;
      logic [VERT_W-1:0]   estimate_vertex;
      logic [WEIGHT_W-1:0] estimate_value;
      logic [VERT_W-1:0]   start_vertex;
      logic [VERT_W-1:0]   goal_vertex;
   } route_req_t;

   logic clock;
   logic reset;

   astar_req_if req_bus ();
   astar_rsp_if rsp_bus ();
   astar_csr_if csr_bus ();

   astar_shortest_path u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus.sink),
      .rsp_port (rsp_bus.source),
      .csr_port (csr_bus.sink)
   );

   // shadow copy of the engine's registers and stores
   logic [VCNT_W-1:0]   shadow_vcount;
   logic [1:0]          shadow_dir;
   logic                shadow_weighted;
   logic                shadow_directed;
   logic [VERT_W-1:0]   shadow_src [NUM_EDGES];
   logic [VERT_W-1:0]   shadow_tgt [NUM_EDGES];
   logic [WEIGHT_W-1:0] shadow_wt  [NUM_EDGES];
   logic                shadow_inf [NUM_EDGES];
   int                  shadow_edges;
   bit                  shadow_overflow;
   logic [WEIGHT_W-1:0] shadow_est [NUM_VERTS];

   rsp_word_type path_words_due[$];
   int  fail_count;
   int  cycle_count;
   bit  idle_enable;
   int  hold_off_cycles;

   // clock and watchdog
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** astar_shortest_path: FAILED **");
         $finish;
      end
   end

   function automatic logic [DIST_W-1:0] sat_sum(logic [DIST_W-1:0] a, logic [DIST_W-1:0] b);
      logic [DIST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DIST_W] ? DIST_MAX : s[DIST_W-1:0];
   endfunction

   function automatic int far_end(int e, int v);
      return (int'(shadow_src[e]) == v) ? int'(shadow_tgt[e]) : int'(shadow_src[e]);
   endfunction

   function automatic void push_status(logic [1:0] st);
      rsp_word_type w;
      w = '0;
      w.status = st;
      w.last   = 1'b1;
      path_words_due.push_back(w);
   endfunction

   // work out the path words one search produces
   function automatic void plan_route(int s, int g);
      int n, dir, u, cur, count, a, b, v;
      logic [DIST_W-1:0] best_dist [NUM_VERTS];
      int par [NUM_VERTS];
      bit opn [NUM_VERTS];
      bit cls [NUM_VERTS];
      int stack [NUM_VERTS];
      logic [DIST_W-1:0] key, bestkey, wgt, alt;
      bit found;
      rsp_word_type w;
      n = (shadow_vcount < NUM_VERTS) ? int'(shadow_vcount) : NUM_VERTS;
      dir = shadow_directed ? int'(shadow_dir) : int'(DIR_ALL);
      if (shadow_overflow) begin
         push_status(STAT_OVERFLOW);
         return;
      end
      if (s >= n || g >= n) begin
         push_status(STAT_RANGE);
         return;
      end
      for (int i = 0; i < NUM_VERTS; i++) begin
         best_dist[i] = DIST_MAX;
         par[i] = 0;
         opn[i] = 0;
         cls[i] = 0;
      end
      best_dist[s] = '0;
      opn[s] = 1;
      found = 0;
      bestkey = '0;
      while (1) begin
         u = n;
         for (int i = 0; i < n; i++) begin
            if (opn[i]) begin
               key = sat_sum(best_dist[i], DIST_W'(shadow_est[i]));
               if (u == n || key < bestkey) begin
                  u = i;
                  bestkey = key;
               end
            end
         end
         if (u == n) break;
         opn[u] = 0;
         cls[u] = 1;
         if (u == g) begin
            found = 1;
            break;
         end
         for (int e = 0; e < shadow_edges; e++) begin
            a = int'(shadow_src[e]);
            b = int'(shadow_tgt[e]);
            if (a >= n || b >= n) continue;
            if (dir == int'(DIR_OUT)) begin
               if (a != u) continue;
               v = b;
            end else if (dir == int'(DIR_IN)) begin
               if (b != u) continue;
               v = a;
            end else if (a == u) v = b;
            else if (b == u) v = a;
            else continue;
            if (shadow_weighted) begin
               if (shadow_inf[e]) continue;
               wgt = DIST_W'(shadow_wt[e]);
            end else begin
               wgt = DIST_W'(UNIT_WEIGHT);
            end
            if (cls[v]) continue;
            alt = sat_sum(best_dist[u], wgt);
            if (!opn[v] || alt < best_dist[v]) begin
               best_dist[v] = alt;
               par[v] = e;
               opn[v] = 1;
            end
         end
      end
      if (!found) begin
         push_status(STAT_UNREACH);
         return;
      end
      count = 0;
      cur = g;
      while (cur != s && count < n) begin
         stack[count++] = par[cur];
         cur = far_end(par[cur], cur);
      end
      cur = s;
      while (count > 0) begin
         count--;
         w = '0;
         w.path_vertex    = VERT_W'(cur);
         w.path_edge      = EDGE_W'(stack[count]);
         w.edge_present   = 1'b1;
         w.total_distance = best_dist[g];
         w.status         = STAT_FOUND;
         path_words_due.push_back(w);
         cur = far_end(stack[count], cur);
      end
      w = '0;
      w.path_vertex    = VERT_W'(g);
      w.total_distance = best_dist[g];
      w.status         = STAT_FOUND;
      w.last           = 1'b1;
      path_words_due.push_back(w);
   endfunction

   // apply one accepted request word to the shadow state
   function automatic void absorb_request(route_req_t r);
      case (r.mode)
         MODE_CLEAR: begin
            shadow_edges = 0;
            shadow_overflow = 0;
         end
         MODE_EDGE: begin
            if (shadow_edges >= NUM_EDGES) begin
               shadow_overflow = 1;
            end else begin
               shadow_src[shadow_edges] = r.edge_from;
               shadow_tgt[shadow_edges] = r.edge_to;
               shadow_wt[shadow_edges]  = r.edge_weight;
               shadow_inf[shadow_edges] = r.weight_infinite;
               shadow_edges++;
            end
         end
         MODE_ESTIMATE: shadow_est[r.estimate_vertex] = r.estimate_value;
         default: plan_route(int'(r.start_vertex), int'(r.goal_vertex));
      endcase
   endfunction

   // drive one request word, with an optional random gap first
   task automatic push_request(route_req_t r);
      int gap;
      @(negedge clock);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           = 1'b1;
      req_bus.mode            = r.mode;
      req_bus.edge_from       = r.edge_from;
      req_bus.edge_to         = r.edge_to;
      req_bus.edge_weight     = r.edge_weight;
      req_bus.weight_infinite = r.weight_infinite;
      req_bus.estimate_vertex = r.estimate_vertex;
      req_bus.estimate_value  = r.estimate_value;
      req_bus.start_vertex    = r.start_vertex;
      req_bus.goal_vertex     = r.goal_vertex;
      do @(posedge clock); while (!req_bus.ready);
      absorb_request(r);
   endtask

   task automatic drop_valid();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   function automatic route_req_t blank_req(logic [1:0] m);
      route_req_t r;
      r.mode = m;
      r.edge_from = VERT_W'($urandom);
      r.edge_to = VERT_W'($urandom);
      r.edge_weight = WEIGHT_W'($urandom);
      r.weight_infinite = 1'($urandom);
      r.estimate_vertex = VERT_W'($urandom);
      r.estimate_value = WEIGHT_W'($urandom);
      r.start_vertex = VERT_W'($urandom);
      r.goal_vertex = VERT_W'($urandom);
      return r;
   endfunction

   task automatic send_clear();
      push_request(blank_req(MODE_CLEAR));
   endtask

   task automatic send_edge(int f, int t, logic [WEIGHT_W-1:0] w, logic inf);
      route_req_t r;
      r = blank_req(MODE_EDGE);
      r.edge_from = VERT_W'(f);
      r.edge_to = VERT_W'(t);
      r.edge_weight = w;
      r.weight_infinite = inf;
      push_request(r);
   endtask

   task automatic send_estimate(int v, logic [WEIGHT_W-1:0] val);
      route_req_t r;
      r = blank_req(MODE_ESTIMATE);
      r.estimate_vertex = VERT_W'(v);
      r.estimate_value = val;
      push_request(r);
   endtask

   task automatic send_search(int s, int g);
      route_req_t r;
      r = blank_req(MODE_SEARCH);
      r.start_vertex = VERT_W'(s);
      r.goal_vertex = VERT_W'(g);
      push_request(r);
   endtask

   // wait for the engine to drain before touching a register
   task automatic settle();
      drop_valid();
      while (path_words_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = val;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_VERTEX_COUNT:   shadow_vcount = val;
         CSR_DIRECTION_MODE: shadow_dir = val[1:0];
         CSR_USE_WEIGHTS:    shadow_weighted = val[0];
         CSR_GRAPH_DIRECTED: shadow_directed = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic write_all_regs(int vc, int dir, int wt, int drc);
      settle();
      write_reg(CSR_VERTEX_COUNT, CSR_DATA_W'(vc));
      write_reg(CSR_DIRECTION_MODE, CSR_DATA_W'(dir));
      write_reg(CSR_USE_WEIGHTS, CSR_DATA_W'(wt));
      write_reg(CSR_GRAPH_DIRECTED, CSR_DATA_W'(drc));
   endtask

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return WEIGHT_W'($urandom);
         2: return '1;
         default: return WEIGHT_W'($urandom_range(1, 8 << FRAC_BITS));
      endcase
   endfunction

   function automatic int pick_vertex(int nv);
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, nv - 1);
   endfunction

   // hand-picked graph: a chain with a costly shortcut, a skipped edge and wrap-around
   task automatic test_directed();
      send_clear();
      send_edge(0, 1, UNIT_WEIGHT, 1'b0);
      send_edge(1, 2, 2 * UNIT_WEIGHT, 1'b0);
      send_edge(0, 2, '1, 1'b0);
      send_edge(2, 3, '0, 1'b1);
      send_edge(2, 3, '0, 1'b0);
      send_edge(3, 63, UNIT_WEIGHT >> 1, 1'b0);
      send_edge(63, 0, UNIT_WEIGHT, 1'b0);
      send_estimate(63, '1);
      send_estimate(1, '0);
      send_search(0, 63);
      send_search(0, 0);
      send_search(3, 0);
      send_search(5, 0);
      send_search(63, 2);
      // shrink the graph so that vertex 63 drops out of range
      write_all_regs(4, DIR_OUT, 1, 1);
      send_search(0, 3);
      send_search(0, 63);
      send_search(63, 0);
      send_search(3, 0);
      // unweighted undirected walk takes the infinite edge too
      write_all_regs(64, DIR_IN, 0, 0);
      send_search(3, 0);
      send_search(0, 3);
      send_estimate(1, '0);
   endtask

   // fill the edge table past its end, then recover with a clear
   task automatic test_overflow();
      write_all_regs(64, DIR_OUT, 1, 1);
      send_clear();
      for (int i = 0; i < NUM_EDGES; i++)
         send_edge(i % 8, (i + 1) % 8, pick_weight(), 1'b0);
      send_search(0, 5);
      send_edge(7, 0, UNIT_WEIGHT, 1'b0);
      send_search(0, 5);
      send_search(63, 63);
      send_clear();
      send_edge(0, 5, UNIT_WEIGHT, 1'b0);
      send_search(0, 5);
   endtask

   // one phase of random graph building and searching under a given setting
   task automatic run_phase(int vc, int dir, int wt, int drc, int edges, int searches);
      int nv, f;
      write_all_regs(vc, dir, wt, drc);
      nv = (vc > NUM_VERTS) ? NUM_VERTS : vc;
      send_clear();
      for (int i = 0; i < edges; i++) begin
         // mostly a chain so that searches get deep; the rest random edges
         if (i < nv - 1 && $urandom_range(0, 2) != 0)
            send_edge(i, i + 1, pick_weight(), $urandom_range(0, 7) == 0);
         else
            send_edge(pick_vertex(nv), pick_vertex(nv), pick_weight(),
                      $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 5) == 0) begin
            f = $urandom_range(0, 2);
            send_estimate(pick_vertex(nv), f == 0 ? WEIGHT_W'($urandom) :
                          WEIGHT_W'($urandom_range(0, 3 << FRAC_BITS)));
         end
      end
      for (int i = 0; i < searches; i++) begin
         if ($urandom_range(0, 9) == 0)
            send_edge(pick_vertex(nv), pick_vertex(nv), pick_weight(), 1'($urandom));
         send_search(pick_vertex(nv), pick_vertex(nv));
      end
   endtask

   // sweep settings with random graphs, extremes included
   task automatic test_random_sweep();
      run_phase(1, DIR_OUT, 1, 1, 2, 2);
      run_phase(8, DIR_OUT, 1, 1, 6, 3);
      run_phase(12, DIR_IN, 1, 1, 6, 3);
      run_phase(10, 3, 0, 1, 6, 2);
      run_phase(16, DIR_ALL, 1, 0, 6, 3);
      run_phase(127, DIR_OUT, 1, 1, 8, 2);
      run_phase(64, DIR_ALL, 0, 0, 6, 2);
   endtask

   // hold the result side off while searches keep coming
   task automatic test_backpressure();
      write_all_regs(8, DIR_ALL, 1, 0);
      send_clear();
      for (int i = 0; i < 7; i++) send_edge(i, i + 1, pick_weight(), 1'b0);
      hold_off_cycles = 400;
      for (int i = 0; i < 6; i++) send_search(0, $urandom_range(0, 7));
   endtask

   // final stretch runs flat out on both sides
   task automatic test_full_rate();
      settle();
      idle_enable = 0;
      run_phase(6, DIR_OUT, 1, 1, 5, 3);
   endtask

   // result side: ready bursts and the long hold-off
   initial begin
      int burst;
      rsp_bus.ready = 1'b0;
      burst = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_bus.ready = 1'b0;
         end else if (burst > 0) begin
            burst--;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 15);
            rsp_bus.ready = ~rsp_bus.ready;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // check each accepted path word against the oldest prediction
   always @(posedge clock) begin
      rsp_word_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (path_words_due.size() == 0) begin
            $error("unexpected path word, vertex %0d", rsp_bus.path_vertex);
            fail_count++;
         end else begin
            due = path_words_due.pop_front();
            if (rsp_bus.path_vertex !== due.path_vertex) begin
               $error("path_vertex: expected %0d, got %0d", due.path_vertex,
                      rsp_bus.path_vertex);
               fail_count++;
            end
            if (rsp_bus.path_edge !== due.path_edge) begin
               $error("path_edge: expected %0d, got %0d", due.path_edge, rsp_bus.path_edge);
               fail_count++;
            end
            if (rsp_bus.edge_present !== due.edge_present) begin
               $error("edge_present: expected %0d, got %0d", due.edge_present,
                      rsp_bus.edge_present);
               fail_count++;
            end
            if (rsp_bus.total_distance !== due.total_distance) begin
               $error("total_distance: expected %0h, got %0h", due.total_distance,
                      rsp_bus.total_distance);
               fail_count++;
            end
            if (rsp_bus.status !== due.status) begin
               $error("status: expected %0d, got %0d", due.status, rsp_bus.status);
               fail_count++;
            end
            if (rsp_bus.last !== due.last) begin
               $error("last: expected %0d, got %0d", due.last, rsp_bus.last);
               fail_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      fail_count = 0;
      cycle_count = 0;
      idle_enable = 1;
      hold_off_cycles = 0;
      shadow_vcount = VERTS_FULL;
      shadow_dir = DIR_OUT;
      shadow_weighted = 1'b1;
      shadow_directed = 1'b1;
      shadow_edges = 0;
      shadow_overflow = 0;
      for (int i = 0; i < NUM_VERTS; i++) shadow_est[i] = '0;
      req_bus.valid = 1'b0;
      req_bus.mode = MODE_CLEAR;
      req_bus.edge_from = '0;
      req_bus.edge_to = '0;
      req_bus.edge_weight = '0;
      req_bus.weight_infinite = 1'b0;
      req_bus.estimate_vertex = '0;
      req_bus.estimate_value = '0;
      req_bus.start_vertex = '0;
      req_bus.goal_vertex = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_VERTEX_COUNT;
      csr_bus.data = '0;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_overflow();
      test_random_sweep();
      test_backpressure();
      test_full_rate();

      drop_valid();
      while (path_words_due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("** astar_shortest_path: PASSED **");
      end else begin
         $display("** astar_shortest_path: FAILED **");
      end
      $finish;
   end

endmodule

[files.f]
rtl/astar_pkg.sv
rtl/astar_ifs.sv
rtl/astar_shortest_path.sv
bench/tb_astar_shortest_path.sv
